// ===== rtl/ffba_pkg.sv =====
// shared types and constants for the first-fit block allocator
package ffba_pkg;

  localparam int unsigned AlignBytes = 4;
  localparam int unsigned AddrBits   = 15;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [AddrBits-1:0] request_bytes;
    logic [AddrBits-1:0] block_address;
  } ffba_req_t;

  typedef struct packed {
    logic [AddrBits-1:0] granted_address;
    logic                status;
    logic [31:0]         alloc_total;
    logic [31:0]         free_total;
    logic [31:0]         live_total;
  } ffba_rsp_t;

  // commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_CLR_STEP  = 4'd1,
    CMD_LOAD_REQ  = 4'd2,
    CMD_RD_CUR    = 4'd3,
    CMD_LATCH_CUR = 4'd4,
    CMD_RD_NXT    = 4'd5,
    CMD_LATCH_NXT = 4'd6,
    CMD_ABSORB    = 4'd7,
    CMD_ADVANCE   = 4'd8,
    CMD_SPLIT_WR  = 4'd9,
    CMD_GRANT_WR  = 4'd10,
    CMD_FREE_WR   = 4'd11,
    CMD_RESPOND   = 4'd12,
    CMD_RESTART   = 4'd13
  } ffba_cmd_e;

  typedef struct packed {
    ffba_cmd_e cmd;
    logic      fail;
    logic      count_free;
  } ffba_ctl_t;

  typedef struct packed {
    logic clr_done;
    logic cur_fits;
    logic cur_end;
    logic cur_used;
    logic cur_valid;
    logic nxt_used;
    logic need_split;
    logic free_ok;
    logic [1:0] op;
  } ffba_sts_t;

endpackage

// ===== rtl/ffba_ram.sv =====
// generic single-port ram with registered read
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/ffba_datapath.sv =====
// datapath: header memory, list walk registers, counters
module ffba_datapath #(
  parameter int unsigned LiveUnits   = 8192,
  parameter int unsigned HeaderUnits = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffba_pkg::ffba_req_t req_i,
  input  ffba_pkg::ffba_ctl_t ctl_i,
  output ffba_pkg::ffba_sts_t sts_o,
  output ffba_pkg::ffba_rsp_t rsp_o
);
  import ffba_pkg::*;

  localparam int unsigned UW = $clog2(LiveUnits);
  // sizes share the width of a rounded request, which can reach 8192 units
  localparam int unsigned SW = AddrBits - 1;
  // header: next, size, used, here, end
  localparam int unsigned HW = UW + SW + 3;
  localparam logic [UW-1:0] EndUnit = UW'(LiveUnits - HeaderUnits);
  localparam logic [SW-1:0] Hu = SW'(HeaderUnits);

  logic [1:0]    op_q;
  logic [SW-1:0] want_q;
  logic [AddrBits-1:0] addr_q;
  logic [UW-1:0] cur_q, nxt_q, ram_addr;
  logic [UW-1:0] cnxt_q, nnxt_q;
  logic [SW-1:0] csize_q, nsize_q;
  logic          cused_q, chere_q, cend_q, nused_q, nend_q;
  logic [UW:0]   clr_q;
  logic          ram_we;
  logic [HW-1:0] ram_wdata, ram_rdata, ram_rdata_fix;
  logic [31:0]   alloc_q, free_q;
  logic [AddrBits-1:0] grant_q;
  logic          status_q;
  logic [SW-1:0] rem_size;
  logic [UW-1:0] split_unit;
  logic [SW+1:0] want_split;
  logic [AddrBits-1:0] req_one;
  logic [AddrBits-1:0] free_q_unit;

  ffba_ram #(.Width(HW), .Depth(LiveUnits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // clearing pass writes reset image: block at 0, end block, zeros elsewhere
  function automatic logic [HW-1:0] reset_hdr(input logic [UW-1:0] u);
    logic [HW-1:0] h;
    h = '0;
    if (u == '0) begin
      h = {EndUnit, SW'(LiveUnits - 2 * HeaderUnits), 1'b0, 1'b1, 1'b0};
    end else if (u == EndUnit) begin
      h = {UW'(0), SW'(0), 1'b1, 1'b1, 1'b1};
    end
    return h;
  endfunction

  assign ram_rdata_fix = ram_rdata;
  assign split_unit = cur_q + UW'(HeaderUnits) + want_q[UW-1:0];
  assign rem_size   = csize_q - want_q - Hu;
  assign want_split = {2'b00, want_q} + {2'b00, Hu} + 1'b1;
  assign req_one    = (req_i.request_bytes == '0) ? AddrBits'(1) : req_i.request_bytes;
  assign free_q_unit = addr_q >> 2;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cur_q;
    ram_wdata = {cnxt_q, csize_q, cused_q, chere_q, cend_q};
    unique case (ctl_i.cmd)
      CMD_CLR_STEP: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q[UW-1:0];
        ram_wdata = reset_hdr(clr_q[UW-1:0]);
      end
      CMD_RD_NXT:   ram_addr = cnxt_q;
      CMD_ABSORB: begin
        ram_we    = 1'b1;
        ram_addr  = nxt_q;
        ram_wdata = {UW'(0), nsize_q, nused_q, 1'b0, nend_q};
      end
      CMD_SPLIT_WR: begin
        ram_we    = 1'b1;
        ram_addr  = split_unit;
        ram_wdata = {cnxt_q, rem_size, 1'b0, 1'b1, 1'b0};
      end
      CMD_GRANT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = sts_o.need_split ? {split_unit, want_q, 1'b1, chere_q, cend_q}
                                     : {cnxt_q, csize_q, 1'b1, chere_q, cend_q};
      end
      CMD_FREE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {cnxt_q, csize_q, 1'b0, chere_q, cend_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      alloc_q  <= '0;
      free_q   <= '0;
      op_q     <= OP_ALLOC;
      cur_q    <= '0;
    end else begin
      case (ctl_i.cmd)
        CMD_CLR_STEP: clr_q <= clr_q + 1'b1;
        CMD_LOAD_REQ: begin
          op_q   <= req_i.opcode;
          want_q <= SW'(({1'b0, req_one} + (AddrBits+1)'(AlignBytes - 1)) >> 2);
          addr_q <= req_i.block_address;
          cur_q  <= (req_i.opcode == OP_FREE)
                    ? UW'((req_i.block_address >> 2) - AddrBits'(HeaderUnits)) : '0;
        end
        CMD_RESTART: cur_q <= '0;
        CMD_LATCH_CUR: begin
          {cnxt_q, csize_q, cused_q, chere_q, cend_q} <= ram_rdata_fix;
        end
        CMD_LATCH_NXT: begin
          nxt_q <= cnxt_q;
          {nsize_q, nused_q, nend_q} <= {ram_rdata_fix[SW+2:3], ram_rdata_fix[2],
                                        ram_rdata_fix[0]};
          nnxt_q <= ram_rdata_fix[HW-1 -: UW];
        end
        CMD_ABSORB: begin
          // fold the next block into the current one, including its header
          csize_q <= csize_q + Hu + nsize_q;
          cnxt_q  <= nnxt_q;
          cend_q  <= nend_q;
          cused_q <= 1'b0;
        end
        CMD_ADVANCE: cur_q <= cnxt_q;
        CMD_RESPOND: begin
          if (op_q == OP_CLEAR) begin
            alloc_q <= '0;
            free_q  <= '0;
          end else if (op_q == OP_ALLOC && !ctl_i.fail) begin
            alloc_q <= alloc_q + 32'd1;
          end else if (ctl_i.count_free) begin
            free_q <= free_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CMD_RESPOND) begin
      status_q <= (op_q == OP_ALLOC) && ctl_i.fail;
      grant_q  <= (op_q == OP_ALLOC && !ctl_i.fail)
                  ? AddrBits'({cur_q + UW'(HeaderUnits), 2'b00}) : '0;
    end
  end

  // the latched current header has been folded with absorbs but nxt_used is
  // looked up through cnxt; after absorb the next header must be reread
  assign sts_o.clr_done   = (clr_q == (UW+1)'(LiveUnits - 1)) ||
                            (clr_q >= (UW+1)'(LiveUnits));
  assign sts_o.cur_fits   = !cused_q && (csize_q >= want_q);
  assign sts_o.cur_end    = cend_q;
  assign sts_o.cur_used   = cused_q;
  assign sts_o.cur_valid  = chere_q && !cend_q;
  assign sts_o.nxt_used   = nused_q;
  assign sts_o.need_split = {2'b00, csize_q} >= want_split;
  assign sts_o.free_ok    = (addr_q != '0) && (addr_q[1:0] == 2'b00) &&
                            (free_q_unit >= AddrBits'(HeaderUnits)) &&
                            ((free_q_unit - AddrBits'(HeaderUnits)) <
                             AddrBits'(LiveUnits));
  assign sts_o.op         = op_q;

  assign rsp_o.granted_address = grant_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.alloc_total     = alloc_q;
  assign rsp_o.free_total      = free_q;
  assign rsp_o.live_total      = alloc_q - free_q;

endmodule

// ===== rtl/ffba_ctrl.sv =====
// controller state machine for list walks, merges and handshakes
module ffba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ffba_pkg::ffba_sts_t sts_i,
  output ffba_pkg::ffba_ctl_t ctl_o
);
  import ffba_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_LAT    = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_NRD    = 4'd5;
  localparam logic [3:0] S_NLAT   = 4'd6;
  localparam logic [3:0] S_MERGE  = 4'd7;
  localparam logic [3:0] S_SPLIT  = 4'd8;
  localparam logic [3:0] S_GRANT  = 4'd9;
  localparam logic [3:0] S_FREEW  = 4'd10;
  localparam logic [3:0] S_RESP   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       merging_q, merging_d;  // 0 first search, 1 merge pass, 2nd search via retry_q
  logic       retry_q, retry_d;
  logic       fail_q, fail_d;
  logic       cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    merging_d   = merging_q;
    retry_d     = retry_q;
    fail_d      = fail_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    ctl_o.cmd   = CMD_NONE;
    ctl_o.fail  = fail_q;
    ctl_o.count_free = cnt_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.cmd = CMD_CLR_STEP;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.cmd = CMD_LOAD_REQ;
          merging_d = 1'b0;
          retry_d   = 1'b0;
          fail_d    = 1'b0;
          cnt_d     = 1'b0;
          state_d   = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.op == OP_FREE && !sts_i.free_ok) begin
          state_d = S_RESP;
        end else if (sts_i.op == OP_ALLOC || sts_i.op == OP_FREE) begin
          ctl_o.cmd = CMD_RD_CUR;
          state_d   = S_LAT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_LAT: begin
        ctl_o.cmd = CMD_LATCH_CUR;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.op == OP_FREE) begin
          if (!sts_i.cur_valid) begin
            state_d = S_RESP;
          end else begin
            cnt_d   = 1'b1;
            state_d = S_NRD;
          end
        end else if (merging_q) begin
          if (sts_i.cur_end) begin
            merging_d = 1'b0;
            retry_d   = 1'b1;
            ctl_o.cmd = CMD_RESTART;
            state_d   = S_RD;
          end else begin
            state_d = S_NRD;
          end
        end else if (sts_i.cur_fits) begin
          state_d = sts_i.need_split ? S_SPLIT : S_GRANT;
        end else if (sts_i.cur_end) begin
          if (retry_q) begin
            fail_d  = 1'b1;
            state_d = S_RESP;
          end else begin
            merging_d = 1'b1;
            ctl_o.cmd = CMD_RESTART;
            state_d   = S_RD;
          end
        end else begin
          ctl_o.cmd = CMD_ADVANCE;
          state_d   = S_RD;
        end
      end
      S_NRD: begin
        ctl_o.cmd = CMD_RD_NXT;
        state_d   = S_NLAT;
      end
      S_NLAT: begin
        ctl_o.cmd = CMD_LATCH_NXT;
        state_d   = S_MERGE;
      end
      S_MERGE: begin
        if (sts_i.op == OP_FREE) begin
          if (!sts_i.nxt_used) begin
            ctl_o.cmd = CMD_ABSORB;
            state_d   = S_FREEW;
          end else begin
            state_d = S_FREEW;
          end
        end else if (!sts_i.cur_used && !sts_i.nxt_used) begin
          ctl_o.cmd = CMD_ABSORB;
          state_d   = S_FREEW;
        end else begin
          ctl_o.cmd = CMD_ADVANCE;
          state_d   = S_RD;
        end
      end
      S_FREEW: begin
        // write back the current header, then keep merging forward
        if (sts_i.op == OP_FREE) begin
          ctl_o.cmd = CMD_FREE_WR;
          state_d   = (sts_i.cur_end || sts_i.nxt_used) ? S_RESP : S_NRD;
        end else begin
          ctl_o.cmd = CMD_FREE_WR;
          state_d   = S_RD;
        end
      end
      S_SPLIT: begin
        ctl_o.cmd = CMD_SPLIT_WR;
        state_d   = S_GRANT;
      end
      S_GRANT: begin
        ctl_o.cmd = CMD_GRANT_WR;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.cmd   = CMD_RESPOND;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      merging_q   <= 1'b0;
      retry_q     <= 1'b0;
      fail_q      <= 1'b0;
      cnt_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      merging_q   <= merging_d;
      retry_q     <= retry_d;
      fail_q      <= fail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/first_fit_block_allocator.sv =====
// top level of the first-fit block allocator
// Usage:
// - in channel (in_valid_i/in_ready_o, in_data_i) takes one transaction:
//   allocate, free or clear counters; out channel (out_valid_o/out_ready_i,
//   out_data_o) returns exactly one result transaction per request.
// - one request is in flight at a time; in_ready_o is high only when idle.
// - latency depends on the block list: allocate reads each block header
//   visited in header memory (one read port, registered read), plus a
//   merge pass over the list when the first search fails, then a second
//   search; free merges forward over the free blocks that follow it.
//   Clear counters and null or misaligned frees go straight to the result.
// - after reset a clearing pass writes every header word, one per cycle,
//   so nothing is accepted until all POOL_UNITS (at most 8192) are written.
// - a finished result waits in the output register while out_ready_i is low;
//   the next request is taken and worked on meanwhile, and its result is
//   held back until the previous one has been taken.
module first_fit_block_allocator #(
  parameter int unsigned POOL_UNITS   = 8192,
  parameter int unsigned HEADER_UNITS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffba_pkg::ffba_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ffba_pkg::ffba_rsp_t out_data_o
);
  import ffba_pkg::*;

  localparam int unsigned LiveUnits = (POOL_UNITS < 8192) ? POOL_UNITS : 8192;

  ffba_ctl_t ctl;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ffba_datapath #(.LiveUnits(LiveUnits), .HeaderUnits(HEADER_UNITS)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_data_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .rsp_o (out_data_o)
  );

endmodule

// ===== rtl/ffba_checker.sv =====
// port-level checker for the allocator, bound to the top level
module ffba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ffba_pkg::ffba_rsp_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.live_total ==
                    out_data_o.alloc_total - out_data_o.free_total)
    else $error("live total mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.granted_address == '0)
    else $error("failed allocate reported an address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ===== bench/tb.sv =====
// self-checking testbench for the first-fit block allocator
`timescale 1ns / 100ps

module tb;
  import ffba_pkg::*;

  localparam int unsigned UNITS     = 8192;
  localparam int unsigned HDR       = 3;
  localparam int unsigned N_RANDOM  = 830;
  localparam int unsigned TAIL_LEN  = 80;
  localparam int unsigned MAX_LIVE  = 40;
  localparam int unsigned CYCLE_CAP = 5000000;

  typedef logic [12:0] unit_t;
  typedef enum logic [2:0] {
    K_FIXED, K_FREE_OLDEST, K_FREE_LIVE, K_REFREE, K_ALLOC_RAND
  } item_kind_e;
  typedef struct {
    item_kind_e kind;
    ffba_req_t  req;
    bit         drain;
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  ffba_req_t in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  ffba_rsp_t out_data_o;

  first_fit_block_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // heap shadow state
  unit_t       nxt_q [UNITS];
  unit_t       size_q[UNITS];
  bit          used_q[UNITS];
  bit          here_q[UNITS];
  bit          end_q [UNITS];
  logic [31:0] allocs, frees;

  pending_t          pending[$];
  ffba_rsp_t         expected_rsp[$];
  logic [14:0]       live_addrs[$];
  logic [14:0]       last_freed;
  int unsigned       errors = 0;
  int unsigned       cycles = 0;
  int unsigned       in_gap = 0, out_gap = 0;
  bit                quiet = 0;
  bit                tail = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic bit find_fit(input logic [13:0] want, output unit_t at);
    unit_t b;
    b = '0;
    forever begin
      if (!used_q[b] && size_q[b] >= want) begin
        at = b;
        return 1;
      end
      if (end_q[b]) return 0;
      b = nxt_q[b];
    end
  endfunction

  function automatic void absorb(input unit_t b);
    unit_t n;
    n = nxt_q[b];
    size_q[b] = unit_t'(size_q[b] + HDR + size_q[n]);
    nxt_q[b] = nxt_q[n];
    here_q[n] = 0;
  endfunction

  function automatic void merge_free_runs();
    unit_t b;
    b = '0;
    while (!end_q[b]) begin
      if (!used_q[b] && !used_q[nxt_q[b]]) absorb(b);
      else b = nxt_q[b];
    end
  endfunction

  function automatic void heap_reset();
    unit_t s;
    s = unit_t'(UNITS - HDR);
    for (int i = 0; i < UNITS; i++) begin
      nxt_q[i] = '0; size_q[i] = '0; used_q[i] = 0; here_q[i] = 0; end_q[i] = 0;
    end
    size_q[0] = unit_t'(UNITS - 2 * HDR);
    nxt_q[0] = s;
    here_q[0] = 1;
    used_q[s] = 1;
    here_q[s] = 1;
    end_q[s] = 1;
    allocs = '0;
    frees = '0;
  endfunction

  function automatic ffba_rsp_t heap_step(input ffba_req_t r);
    ffba_rsp_t   rsp;
    logic [13:0] want;
    logic [15:0] req;
    unit_t       b, tailu;
    bit          ok;
    int unsigned q;
    rsp = '0;
    case (r.opcode)
      OP_ALLOC: begin
        req = (r.request_bytes == 0) ? 16'd1 : 16'(r.request_bytes);
        want = 14'((req + 3) / 4);
        ok = find_fit(want, b);
        if (!ok) begin
          merge_free_runs();
          ok = find_fit(want, b);
        end
        if (ok) begin
          if (size_q[b] >= want + HDR + 1) begin
            tailu = unit_t'(b + HDR + want);
            size_q[tailu] = unit_t'(size_q[b] - want - HDR);
            used_q[tailu] = 0;
            here_q[tailu] = 1;
            end_q[tailu] = 0;
            nxt_q[tailu] = nxt_q[b];
            size_q[b] = unit_t'(want);
            nxt_q[b] = tailu;
          end
          used_q[b] = 1;
          allocs++;
          rsp.granted_address = 15'((b + HDR) * 4);
        end else begin
          rsp.status = 1'b1;
        end
      end
      OP_FREE: begin
        q = r.block_address / 4;
        if (r.block_address != 0 && r.block_address[1:0] == 2'b00 && q >= HDR) begin
          b = unit_t'(q - HDR);
          if (here_q[b] && !end_q[b]) begin
            used_q[b] = 0;
            while (!end_q[b] && !used_q[nxt_q[b]]) absorb(b);
            frees++;
          end
        end
      end
      OP_CLEAR: begin
        allocs = '0;
        frees = '0;
      end
      default: ;
    endcase
    rsp.alloc_total = allocs;
    rsp.free_total = frees;
    rsp.live_total = allocs - frees;
    return rsp;
  endfunction

  function automatic ffba_req_t make_req(input logic [1:0] op, input int unsigned bytes,
                                         input int unsigned addr);
    ffba_req_t r;
    r.opcode = op;
    r.request_bytes = 15'(bytes);
    r.block_address = 15'(addr);
    return r;
  endfunction

  function automatic void add(input item_kind_e k, input ffba_req_t r, input bit d = 0);
    pending_t p;
    p.kind = k;
    p.req = r;
    p.drain = d;
    pending.push_back(p);
  endfunction

  // turn a pending item into a concrete transaction, using the current live list
  function automatic ffba_req_t resolve(input pending_t p);
    ffba_req_t   r;
    int unsigned idx;
    r = p.req;
    case (p.kind)
      K_FREE_OLDEST, K_FREE_LIVE: begin
        if (live_addrs.size() == 0) begin
          r = make_req(OP_FREE, $urandom_range(0, 32767), $urandom_range(0, 8191) * 4);
        end else begin
          idx = (p.kind == K_FREE_OLDEST) ? 0 : $urandom_range(0, live_addrs.size() - 1);
          r.block_address = live_addrs[idx];
          live_addrs.delete(idx);
        end
        last_freed = r.block_address;
      end
      K_REFREE: r.block_address = last_freed;
      K_ALLOC_RAND: begin
        if (live_addrs.size() > MAX_LIVE) begin
          idx = $urandom_range(0, live_addrs.size() - 1);
          r = make_req(OP_FREE, $urandom_range(0, 32767), live_addrs[idx]);
          live_addrs.delete(idx);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    ffba_rsp_t rsp;
    logic      v_next;
    ffba_req_t d_next;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        rsp = heap_step(in_data_i);
        expected_rsp.push_back(rsp);
        if (in_data_i.opcode == OP_ALLOC && !rsp.status)
          live_addrs.push_back(rsp.granted_address);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        v_next = 1'b0;
        d_next = in_data_i;
        if (pending.size() <= TAIL_LEN) tail = 1;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0 && !(pending[0].drain && expected_rsp.size() > 0)) begin
          d_next = resolve(pending.pop_front());
          v_next = 1'b1;
          if ($urandom_range(0, 49) == 0) quiet = !quiet;
          if (!tail && !quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 16);
        end
        in_valid_i <= v_next;
        in_data_i <= d_next;
      end
    end
  end

  // monitor and result checker
  always @(posedge clk_i) begin
    ffba_rsp_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          e = expected_rsp.pop_front();
          if (out_data_o.granted_address !== e.granted_address)
            report($sformatf("granted_address %0d, want %0d",
                             out_data_o.granted_address, e.granted_address));
          if (out_data_o.status !== e.status)
            report($sformatf("status %0d, want %0d", out_data_o.status, e.status));
          if (out_data_o.alloc_total !== e.alloc_total)
            report($sformatf("alloc_total %0d, want %0d",
                             out_data_o.alloc_total, e.alloc_total));
          if (out_data_o.free_total !== e.free_total)
            report($sformatf("free_total %0d, want %0d",
                             out_data_o.free_total, e.free_total));
          if (out_data_o.live_total !== e.live_total)
            report($sformatf("live_total %0d, want %0d",
                             out_data_o.live_total, e.live_total));
        end
      end
      if (tail) begin
        out_ready_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    heap_reset();
    // fragment the heap, then force a coalescing pass
    add(K_FIXED, make_req(OP_ALLOC, 0, 0));
    add(K_FIXED, make_req(OP_ALLOC, 1, 0));
    add(K_FIXED, make_req(OP_ALLOC, 4, 0));
    add(K_FIXED, make_req(OP_ALLOC, 5, 0));
    repeat (4) add(K_FREE_OLDEST, make_req(OP_FREE, 0, 0));
    add(K_FIXED, make_req(OP_ALLOC, 32744, 0), 1);
    add(K_FIXED, make_req(OP_ALLOC, 1, 0));
    add(K_FREE_OLDEST, make_req(OP_FREE, 0, 0));
    add(K_FIXED, make_req(OP_FREE, 0, 0));
    add(K_FIXED, make_req(OP_FREE, 0, 2));
    add(K_FIXED, make_req(OP_FREE, 0, 8));
    add(K_FIXED, make_req(OP_FREE, 0, 100));
    add(K_FIXED, make_req(OP_FREE, 0, 32764));
    add(K_FIXED, make_req(OP_ALLOC, 32767, 0));
    // double free of the same block
    add(K_FIXED, make_req(OP_ALLOC, 8, 0));
    add(K_FREE_OLDEST, make_req(OP_FREE, 0, 0));
    add(K_REFREE, make_req(OP_FREE, 0, 0));
    add(K_FIXED, make_req(2'd3, 32767, 32767));
    // live count wraps below zero after a clear
    add(K_FIXED, make_req(OP_ALLOC, 100, 0));
    add(K_FIXED, make_req(OP_CLEAR, 0, 0));
    add(K_FREE_OLDEST, make_req(OP_FREE, 0, 0), 1);
    for (int i = 0; i < N_RANDOM; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45)
        add(K_ALLOC_RAND, make_req(OP_ALLOC,
            ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 256),
            $urandom_range(0, 32767)));
      else if (roll < 85)
        add(K_FREE_LIVE, make_req(OP_FREE, $urandom_range(0, 32767), 0), i % 300 == 150);
      else if (roll < 93)
        add(K_FIXED, make_req(OP_FREE, $urandom_range(0, 32767), $urandom_range(0, 32767)));
      else if (roll < 97)
        add(K_FIXED, make_req(OP_CLEAR, $urandom_range(0, 32767), $urandom_range(0, 32767)));
      else
        add(K_FIXED, make_req(2'd3, $urandom_range(0, 32767), $urandom_range(0, 32767)));
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending.size() == 0 && !in_valid_i && expected_rsp.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
